/* rtl/gpca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Place-cell grid package
// Payload structs, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package gpca_pkg;

   typedef struct packed {
      logic signed [15:0] obs_x;
      logic signed [15:0] obs_y;
   } req_type;

   typedef struct packed {
      logic [5:0]  cell_index;
      logic [16:0] activation_value;
      logic        last_cell;
   } rsp_type;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_INV_X    = 3'd2;
   localparam logic [2:0] REG_INV_Y    = 3'd3;
   localparam logic [2:0] REG_CELLS_X  = 3'd4;
   localparam logic [2:0] REG_CELLS_Y  = 3'd5;

   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
   localparam int EXP_TERMS = 12;

endpackage

/* rtl/gpca_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 40 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpca_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [39:0] quotient
);
   logic [39:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[39]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/grid_place_cell_activation.sv */
`timescale 1ns / 1ps
// Each cell passes through a distance pass (25-step square root) and an activation pass
// (restoring divider, then 12 series terms, each a multiply and a restoring division).
// With a zero distance total the activation pass skips the divider and the series.
// One observation at a time: a new request is accepted only in the idle state.
// Reset: synchronous; registers return to their defaults, the store is not cleared.
// ----------------------------------------------------------------------------
// Place-cell grid activation
// Two passes over a distance memory: distances and their sum, then exp(-d/sum).
// ----------------------------------------------------------------------------
module grid_place_cell_activation #(
   parameter int MAX_CELLS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gpca_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gpca_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import gpca_pkg::*;

   localparam int AW = $clog2(MAX_CELLS);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_AXIS  = 11'b00000000010,
      ST_SQ    = 11'b00000000100,
      ST_SQRT  = 11'b00000001000,
      ST_RD    = 11'b00000010000,
      ST_DIV   = 11'b00000100000,
      ST_EXPM  = 11'b00001000000,
      ST_EXPD  = 11'b00010000000,
      ST_OUT   = 11'b00100000000,
      ST_MEM   = 11'b01000000000,
      ST_LOAD  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] org_x_ff, org_y_ff;
   logic [15:0] inv_x_ff, inv_y_ff;
   logic [3:0]  cx_ff, cy_ff;

   logic signed [15:0] obs_x_ff, obs_y_ff;
   logic [3:0]  ncx_ff;
   logic [6:0]  ncells_ff;
   logic [6:0]  k_ff;
   logic [2:0]  ix_ff, iy_ff;
   logic [31:0] total_ff;

   logic [23:0] ax_ff, ay_ff;
   logic [48:0] rad_ff;
   logic [48:0] res_ff;
   logic [49:0] bit_ff;

   logic [23:0] mem [MAX_CELLS];
   logic [23:0] rd_ff;

   logic        div_start;
   logic        div_done;
   logic [39:0] div_q;

   logic [31:0] x_ff;
   logic [31:0] term_ff;
   logic signed [33:0] acc_ff;
   logic [3:0]  n_ff;
   logic [31:0] tdiv_q_ff, tdiv_r_ff;
   logic [4:0]  tdiv_cnt_ff;

   rsp_type out_ff;
   logic    out_valid_ff;

   // Cell count after clamping.
   function automatic logic [3:0] clampc(input logic [3:0] c);
      if (c < 4'd2) return 4'd2;
      if (c > 4'd8) return 4'd8;
      return c;
   endfunction

   // Offset along one axis, Q16.8 magnitude saturated.
   function automatic logic [23:0] axis_off(input logic [2:0] idx,
                                            input logic signed [15:0] obs,
                                            input logic signed [15:0] org,
                                            input logic [15:0] inv);
      logic signed [17:0] diff;
      logic signed [35:0] d;
      logic [35:0] mag;
      diff = 18'(obs) - 18'(org);
      d    = 36'(signed'({1'b0, idx, 16'h0})) - diff * signed'({1'b0, inv});
      mag  = d[35] ? 36'(-d) : d;
      mag  = mag >> 8;
      return (mag > 36'(DIST_MAX)) ? DIST_MAX : mag[23:0];
   endfunction

   gpca_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({rd_ff, 16'h0}),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign div_start = (state_ff == ST_LOAD);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   logic [48:0] sq_sum;
   logic [49:0] trial;
   logic [63:0] acc_q;
   logic [6:0]  n_cells;
   logic [23:0] dist_sat;
   logic [16:0] r_clamp;
   logic [63:0] prod;
   logic [31:0] t_shift;
   logic        t_ge;
   logic [31:0] tq_next;
   assign sq_sum  = 49'({24'd0, ax_ff} * {24'd0, ax_ff})
                  + 49'({24'd0, ay_ff} * {24'd0, ay_ff});
   assign trial   = 50'(res_ff) + bit_ff;
   assign dist_sat = (res_ff > 49'(DIST_MAX)) ? DIST_MAX : res_ff[23:0];
   assign n_cells = (7'(clampc(cx_ff)) * 7'(clampc(cy_ff)) > 7'(MAX_CELLS))
                    ? 7'(MAX_CELLS) : 7'(clampc(cx_ff)) * 7'(clampc(cy_ff));
   assign acc_q   = 64'($unsigned(acc_ff)) + 64'd8192;
   assign r_clamp = (div_q > 40'd65536) ? 17'd65536 : div_q[16:0];
   assign prod    = 64'(term_ff) * 64'(x_ff);
   // One restoring step of the series term divided by its term number.
   assign t_shift = {tdiv_r_ff[30:0], tdiv_q_ff[31]};
   assign t_ge    = (t_shift >= 32'(n_ff));
   assign tq_next = {tdiv_q_ff[30:0], t_ge};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_AXIS;
         ST_AXIS: state_in = ST_SQ;
         ST_SQ:   state_in = ST_SQRT;
         ST_SQRT: if (bit_ff == '0) state_in = ST_MEM;
         ST_MEM:  state_in = (k_ff + 7'd1 == ncells_ff) ? ST_RD : ST_AXIS;
         ST_RD:   state_in = (total_ff == '0) ? ST_OUT : ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_EXPM;
         ST_EXPM: state_in = ST_EXPD;
         ST_EXPD: if (tdiv_cnt_ff == 5'd31)
                     state_in = (n_ff == 4'(EXP_TERMS)) ? ST_OUT : ST_EXPM;
         ST_OUT:  if (!out_valid_ff || rsp_ready)
                     state_in = (k_ff + 7'd1 == ncells_ff) ? ST_IDLE : ST_RD;
         default: state_in = ST_IDLE;
      endcase
   end

   // Distance store: one write per cell in the first pass, one registered read per cell in the second.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MEM) mem[k_ff[AW-1:0]] <= dist_sat;
      if (state_ff == ST_RD) rd_ff <= mem[k_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         inv_x_ff     <= 16'd256;
         inv_y_ff     <= 16'd256;
         cx_ff        <= 4'd8;
         cy_ff        <= 4'd8;
         total_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!out_valid_ff || rsp_ready)) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               REG_ORIGIN_X: org_x_ff <= csr_data;
               REG_ORIGIN_Y: org_y_ff <= csr_data;
               REG_INV_X:    inv_x_ff <= csr_data;
               REG_INV_Y:    inv_y_ff <= csr_data;
               REG_CELLS_X:  cx_ff    <= csr_data[3:0];
               REG_CELLS_Y:  cy_ff    <= csr_data[3:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               obs_x_ff  <= req_data.obs_x;
               obs_y_ff  <= req_data.obs_y;
               ncx_ff    <= clampc(cx_ff);
               ncells_ff <= n_cells;
               k_ff      <= '0;
               ix_ff     <= '0;
               iy_ff     <= '0;
               total_ff  <= '0;
            end
            ST_AXIS: begin
               ax_ff <= axis_off(ix_ff, obs_x_ff, org_x_ff, inv_x_ff);
               ay_ff <= axis_off(iy_ff, obs_y_ff, org_y_ff, inv_y_ff);
            end
            ST_SQ: begin
               rad_ff <= sq_sum;
               res_ff <= '0;
               bit_ff <= 50'(1) << 48;
            end
            ST_SQRT: if (bit_ff != '0) begin
               if (50'(rad_ff) >= trial) begin
                  rad_ff <= rad_ff - trial[48:0];
                  res_ff <= 49'((50'(res_ff) >> 1) + bit_ff);
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
            ST_MEM: begin
               total_ff <= total_ff + 32'(dist_sat);
               if (k_ff + 7'd1 == ncells_ff) begin
                  k_ff <= '0;
               end else begin
                  k_ff <= k_ff + 7'd1;
                  if (4'(ix_ff) + 4'd1 == ncx_ff) begin
                     ix_ff <= '0;
                     iy_ff <= iy_ff + 3'd1;
                  end else begin
                     ix_ff <= ix_ff + 3'd1;
                  end
               end
            end
            ST_DIV: if (div_done) begin
               x_ff    <= 32'({r_clamp, 14'd0});
               term_ff <= 32'h4000_0000;
               acc_ff  <= 34'sh4000_0000;
               n_ff    <= '0;
            end
            ST_EXPM: begin
               tdiv_q_ff   <= prod[61:30];
               tdiv_r_ff   <= '0;
               tdiv_cnt_ff <= '0;
               n_ff        <= n_ff + 4'd1;
            end
            ST_EXPD: begin
               tdiv_r_ff   <= t_ge ? t_shift - 32'(n_ff) : t_shift;
               tdiv_q_ff   <= tq_next;
               tdiv_cnt_ff <= tdiv_cnt_ff + 5'd1;
               if (tdiv_cnt_ff == 5'd31) begin
                  term_ff <= tq_next;
                  acc_ff  <= n_ff[0] ? acc_ff - 34'(tq_next) : acc_ff + 34'(tq_next);
               end
            end
            ST_OUT: if (!out_valid_ff || rsp_ready) begin
               out_ff.cell_index  <= k_ff[5:0];
               out_ff.last_cell   <= (k_ff + 7'd1 == ncells_ff);
               if (total_ff == '0) out_ff.activation_value <= 17'd65536;
               else if (acc_ff < 0) out_ff.activation_value <= '0;
               else if ((acc_q >> 14) > 64'd65536) out_ff.activation_value <= 17'd65536;
               else out_ff.activation_value <= acc_q[30:14];
               k_ff <= k_ff + 7'd1;
            end
            default: ;
         endcase
      end
   end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Place-cell grid activation testbench
// Drives observations into the grid block under several grid setups, predicts
// every per-cell activation in fixed point and checks the results in order,
// with random idle bursts on both the observation and the result side.
// ----------------------------------------------------------------------------
module testbench;
   import gpca_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   grid_place_cell_activation uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the grid setup.
   logic signed [15:0] grid_org_x, grid_org_y;
   logic [15:0] grid_inv_x, grid_inv_y;
   logic [3:0] grid_cx, grid_cy;

   rsp_type activation_queue[$];
   int mismatch_count;
   int rsp_count;
   int obs_count;
   int cycle_count;
   bit quiet_phase;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 50000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("grid_place_cell_activation: mismatch");
         $finish;
      end
   end

   // Result side: random stall bursts, none in the quiet phase.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (!quiet_phase && stall_left == 0 && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4);
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (activation_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: cell %0d value %0d last %0b",
                        rsp_data.cell_index, rsp_data.activation_value,
                        rsp_data.last_cell);
         end else begin
            exp_rsp = activation_queue.pop_front();
            if (rsp_data.cell_index !== exp_rsp.cell_index ||
                rsp_data.activation_value !== exp_rsp.activation_value ||
                rsp_data.last_cell !== exp_rsp.last_cell) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("cell mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                           exp_rsp.cell_index, exp_rsp.activation_value,
                           exp_rsp.last_cell, rsp_data.cell_index,
                           rsp_data.activation_value, rsp_data.last_cell);
            end
         end
      end
   end

   function automatic logic [63:0] axis_distance(int unsigned idx,
         logic signed [15:0] obs, logic signed [15:0] org, logic [15:0] inv);
      longint diff;
      longint off;
      longint unsigned mag;
      diff = longint'(obs) - longint'(org);
      off = longint'(idx) * 65536 - diff * longint'(inv);
      mag = (off < 0) ? longint'(-off) : off;
      mag = mag >> 8;
      return (mag > 64'hFFFFFF) ? 64'hFFFFFF : mag;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Truncated Taylor series of exp(-r/65536), rounded to Q1.16.
   function automatic logic [16:0] decay_of(logic [31:0] r);
      logic [63:0] x;
      logic [63:0] term;
      longint acc;
      logic [63:0] q;
      x = 64'(r) << 14;
      term = 64'd1 << 30;
      acc = 1 << 30;
      for (int n = 1; n <= EXP_TERMS; n++) begin
         term = ((term * x) >> 30) / n;
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) return 17'd0;
      q = (64'(acc) + 8192) >> 14;
      return (q > 65536) ? 17'd65536 : q[16:0];
   endfunction

   task automatic predict_activations(req_type obs);
      int unsigned cx, cy, ncells;
      logic [23:0] cell_dist[64];
      logic [31:0] total;
      logic [63:0] ax, ay, d, r;
      rsp_type item;
      cx = (grid_cx < 2) ? 2 : (grid_cx > 8) ? 8 : grid_cx;
      cy = (grid_cy < 2) ? 2 : (grid_cy > 8) ? 8 : grid_cy;
      ncells = cx * cy;
      if (ncells > 64) ncells = 64;
      total = 0;
      for (int k = 0; k < ncells; k++) begin
         ax = axis_distance(k % cx, obs.obs_x, grid_org_x, grid_inv_x);
         ay = axis_distance(k / cx, obs.obs_y, grid_org_y, grid_inv_y);
         d = floor_sqrt(ax * ax + ay * ay);
         if (d > 64'hFFFFFF) d = 64'hFFFFFF;
         cell_dist[k] = d[23:0];
         total = total + d[31:0];
      end
      for (int k = 0; k < ncells; k++) begin
         item.cell_index = k[5:0];
         item.last_cell = (k + 1 == ncells);
         if (total == 0) begin
            item.activation_value = 17'd65536;
         end else begin
            r = (64'(cell_dist[k]) << 16) / total;
            if (r > 65536) r = 65536;
            item.activation_value = decay_of(r[31:0]);
         end
         activation_queue = {activation_queue, item};
      end
   endtask

   task automatic send_observation(logic signed [15:0] x, logic signed [15:0] y);
      req_type obs;
      int gap;
      @(posedge clock);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      obs.obs_x = x;
      obs.obs_y = y;
      predict_activations(obs);
      req_data <= obs;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      obs_count++;
   endtask

   task automatic wait_drained();
      while (activation_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_grid_reg(logic [2:0] idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         REG_ORIGIN_X: grid_org_x = value;
         REG_ORIGIN_Y: grid_org_y = value;
         REG_INV_X:    grid_inv_x = value;
         REG_INV_Y:    grid_inv_y = value;
         REG_CELLS_X:  grid_cx = value[3:0];
         REG_CELLS_Y:  grid_cy = value[3:0];
         default: ;
      endcase
   endtask

   task automatic setup_grid(logic [15:0] ox, logic [15:0] oy, logic [15:0] ix,
                             logic [15:0] iy, logic [3:0] cx, logic [3:0] cy);
      wait_drained();
      write_grid_reg(REG_ORIGIN_X, ox);
      write_grid_reg(REG_ORIGIN_Y, oy);
      write_grid_reg(REG_INV_X, ix);
      write_grid_reg(REG_INV_Y, iy);
      write_grid_reg(REG_CELLS_X, {12'd0, cx});
      write_grid_reg(REG_CELLS_Y, {12'd0, cy});
      csr_write <= 1'b0;
   endtask

   task automatic test_default_grid();
      // Reset setup: full 8 x 8 grid, unit spacing.
      send_observation(16'sd0, 16'sd0);
      send_observation(16'sd896, 16'sd1792);
      send_observation(16'sh7FFF, 16'sh8000);
      send_observation(16'sh8000, 16'sh7FFF);
   endtask

   task automatic test_directed_corners();
      // Zero inverse spacing makes every distance independent of the observation.
      setup_grid(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd2, 4'd2);
      send_observation(16'sh1234, -16'sd77);
      // The observation sits on cell 0 with x cells below range.
      setup_grid(16'h0100, 16'hFF00, 16'h0100, 16'h0100, 4'd0, 4'd3);
      send_observation(16'sh0100, 16'shFF00);
      send_observation(16'sh0000, 16'sh0000);
      // Cell counts above range count as 8.
      setup_grid(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd9);
      send_observation(16'sh7FFF, 16'sh8000);
      send_observation(16'sh8000, 16'sh7FFF);
      setup_grid(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 4'd8, 4'd2);
      send_observation(16'sh0000, 16'shFFFF);
      send_observation(16'shFFFF, 16'sh0000);
      setup_grid(16'h0000, 16'h0000, 16'h0080, 16'h0200, 4'd1, 4'd1);
      send_observation(16'sh0080, 16'sh0080);
      send_observation(16'sh5555, 16'shAAAA);
   endtask

   task automatic test_random_grids();
      logic [3:0] cx, cy;
      for (int phase = 0; phase < 14; phase++) begin
         // Mostly small grids to keep the run short.
         cx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(2, 4));
         cy = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(2, 4));
         setup_grid(16'($urandom), 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1024)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1024)),
                    cx, cy);
         if (phase == 13) quiet_phase = 1'b1;
         for (int i = 0; i < 15; i++) begin
            if ($urandom_range(0, 1) == 0)
               send_observation(16'($urandom), 16'($urandom));
            else
               send_observation(16'(grid_org_x + $urandom_range(0, 2048) - 16'sd256),
                                16'(grid_org_y + $urandom_range(0, 2048) - 16'sd256));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = REG_ORIGIN_X;
      csr_data = '0;
      quiet_phase = 1'b0;
      mismatch_count = 0;
      rsp_count = 0;
      obs_count = 0;
      cycle_count = 0;
      grid_org_x = 0;
      grid_org_y = 0;
      grid_inv_x = 16'd256;
      grid_inv_y = 16'd256;
      grid_cx = 4'd8;
      grid_cy = 4'd8;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grid();
      test_directed_corners();
      test_random_grids();
      while (activation_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d observations and %0d cell results over 20 grid setups",
               obs_count, rsp_count);
      if (mismatch_count == 0 && activation_queue.size() == 0)
         $display("grid_place_cell_activation: match");
      else
         $display("grid_place_cell_activation: mismatch");
      $finish;
   end
endmodule
